// File: rtl/ceh_pkg.sv
`timescale 1ns / 1ps

package ceh_pkg;

	// Table geometry and counter width.
	localparam int GROUPS      = 16;
	localparam int QUAL_LEVELS = 64;
	localparam int MAX_CYCLES  = 256;
	localparam int COUNT_WIDTH = 32;
	localparam int DINUC_CODES = 16;

	// Field widths of one item.
	localparam int RG_W   = 4;
	localparam int QUAL_W = 6;
	localparam int CYC_W  = 8;
	localparam int BASE_W = 3;
	localparam int SEL_W  = 2;
	localparam int DN_W   = 4;
	localparam int OUT_W  = 32;

	localparam logic [BASE_W-1:0] BASE_N = 3'd4;

	// Stream widths.
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 64;

	// Table depths and address widths.
	localparam int G_DEPTH = GROUPS;
	localparam int Q_DEPTH = GROUPS * QUAL_LEVELS;
	localparam int C_DEPTH = Q_DEPTH * 2 * MAX_CYCLES;
	localparam int D_DEPTH = Q_DEPTH * DINUC_CODES;
	localparam int G_AW    = (G_DEPTH > 1) ? $clog2(G_DEPTH) : 1;
	localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int C_AW    = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;
	localparam int D_AW    = (D_DEPTH > 1) ? $clog2(D_DEPTH) : 1;

	typedef enum logic {
		OP_COUNT,
		OP_READ
	} op_t;

	typedef enum logic [SEL_W-1:0] {
		TBL_GROUP,
		TBL_QUAL,
		TBL_CYCLE,
		TBL_DINUC
	} table_sel_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_APPLY
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic clear_wr;
		logic mem_rd;
		logic apply_wr;
		logic load_out;
	} ceh_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_done;
		logic is_readout;
	} ceh_status_t;

	// One table entry.
	typedef struct packed {
		logic [COUNT_WIDTH-1:0] errs;
		logic [COUNT_WIDTH-1:0] obs;
	} tally_t;

endpackage

// File: rtl/ceh_ctrl.sv
`timescale 1ns / 1ps

module ceh_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output ceh_pkg::ceh_cmd_t    cmd,
	input  ceh_pkg::ceh_status_t status
);
	import ceh_pkg::*;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands.
	always_comb begin
		state_next    = state_q;
		cmd           = '0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (status.clear_done) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.capture = 1'b1;
					state_next  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.mem_rd = 1'b1;
				state_next = ST_APPLY;
			end
			ST_APPLY: begin
				if (!status.is_readout) begin
					cmd.apply_wr = 1'b1;
					state_next   = ST_IDLE;
				end else if (!out_valid_q || m_axis_tready) begin
					cmd.load_out = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_CLEAR;
			end
		endcase
	end

	// Output item valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;

	// An accepted item always goes to the table read next.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == ST_READ))
		else $error("accepted item did not start a table read");

	// A result never overwrites one that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || m_axis_tready))
		else $error("result loaded over a waiting result");

	// Clearing and counting never write the tables together.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clear_wr && (cmd.apply_wr || cmd.capture)))
		else $error("table write during clearing pass");

	// A table write back follows a read issued the cycle before.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply_wr |-> $past(cmd.mem_rd))
		else $error("write back without a preceding read");

endmodule

// File: rtl/ceh_datapath.sv
`timescale 1ns / 1ps

module ceh_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ceh_pkg::ceh_cmd_t                cmd,
	output ceh_pkg::ceh_status_t             status,
	input  logic                             in_op,
	input  logic [ceh_pkg::IN_DATA_W-1:0]    in_data,
	output logic [ceh_pkg::OUT_DATA_W-1:0]   out_data
);
	import ceh_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	// Saturating update of one entry.
	function automatic tally_t bump(input tally_t t, input logic err);
		tally_t r;
		r = t;
		if (err && t.errs != CNT_MAX) begin
			r.errs = t.errs + COUNT_WIDTH'(1);
		end
		if (t.obs != CNT_MAX) begin
			r.obs = t.obs + COUNT_WIDTH'(1);
		end
		return r;
	endfunction

	// Counts wider than the output field read out as all ones.
	function automatic logic [OUT_W-1:0] clip(input logic [COUNT_WIDTH-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return (w > 64'h0000_0000_FFFF_FFFF) ? '1 : w[OUT_W-1:0];
	endfunction

	// Field unpacking.
	logic [RG_W-1:0]   rg;
	logic [QUAL_W-1:0] qual;
	logic [CYC_W-1:0]  cyc;
	logic              mate;
	logic [BASE_W-1:0] base;
	logic              skipped;
	logic              err;
	logic [SEL_W-1:0]  sel;
	logic [DN_W-1:0]   dn;

	assign rg      = in_data[3:0];
	assign qual    = in_data[9:4];
	assign cyc     = in_data[17:10];
	assign mate    = in_data[18];
	assign base    = in_data[21:19];
	assign skipped = in_data[22];
	assign err     = in_data[23];
	assign sel     = in_data[25:24];
	assign dn      = in_data[29:26];

	// Index range checks and entry addresses.
	logic        rg_ok, q_ok, c_ok, base_ok, prev_ok, cnt_ok;
	logic [31:0] qi_w, ci_w, dlow_w, di_w;
	logic [BASE_W-1:0] prev_q;

	assign rg_ok   = 32'(rg) < GROUPS;
	assign q_ok    = rg_ok && (32'(qual) < QUAL_LEVELS);
	assign c_ok    = q_ok && (32'(cyc) < MAX_CYCLES);
	assign base_ok = !base[2];
	assign prev_ok = !prev_q[2];
	assign cnt_ok  = !skipped && base_ok;
	assign qi_w    = 32'(rg) * 32'(QUAL_LEVELS) + 32'(qual);
	assign ci_w    = (qi_w * 32'd2 + 32'(mate)) * 32'(MAX_CYCLES) + 32'(cyc);
	assign dlow_w  = (in_op == OP_READ) ? 32'(dn)
		: (32'(prev_q[1:0]) * 32'd4 + 32'(base[1:0]));
	assign di_w    = qi_w * 32'(DINUC_CODES) + dlow_w;

	// Item registers.
	logic [G_AW-1:0]  g_addr_q;
	logic [Q_AW-1:0]  q_addr_q;
	logic [C_AW-1:0]  c_addr_q;
	logic [D_AW-1:0]  d_addr_q;
	logic             err_q;
	table_sel_t       sel_q;
	logic             op_q;
	logic             g_en_q, q_en_q, c_en_q, d_en_q, rd_ok_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			g_addr_q <= G_AW'(rg);
			q_addr_q <= Q_AW'(qi_w);
			c_addr_q <= C_AW'(ci_w);
			d_addr_q <= D_AW'(di_w);
			err_q    <= err;
			sel_q    <= table_sel_t'(sel);
		end
	end

	// Operation, table enables and previous base.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_COUNT;
			g_en_q  <= 1'b0;
			q_en_q  <= 1'b0;
			c_en_q  <= 1'b0;
			d_en_q  <= 1'b0;
			rd_ok_q <= 1'b0;
			prev_q  <= BASE_N;
		end else if (cmd.capture) begin
			op_q   <= in_op;
			g_en_q <= (in_op == OP_COUNT) && cnt_ok && rg_ok;
			q_en_q <= (in_op == OP_COUNT) && cnt_ok && q_ok;
			c_en_q <= (in_op == OP_COUNT) && cnt_ok && c_ok;
			d_en_q <= (in_op == OP_COUNT) && cnt_ok && q_ok && prev_ok && (cyc != '0);
			unique case (table_sel_t'(sel))
				TBL_GROUP: rd_ok_q <= rg_ok;
				TBL_QUAL:  rd_ok_q <= q_ok;
				TBL_CYCLE: rd_ok_q <= c_ok;
				TBL_DINUC: rd_ok_q <= q_ok;
				default:   rd_ok_q <= 1'b0;
			endcase
			if (in_op == OP_COUNT) begin
				prev_q <= base;
			end
		end
	end

	// Clearing pass address.
	logic [C_AW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_q <= C_AW'(32'(clr_q) + 32'd1);
		end
	end

	assign status.clear_done = (32'(clr_q) == C_DEPTH - 1);
	assign status.is_readout = (op_q == OP_READ);

	// Table memories.
	tally_t g_mem [G_DEPTH];
	tally_t q_mem [Q_DEPTH];
	tally_t c_mem [C_DEPTH];
	tally_t d_mem [D_DEPTH];

	tally_t g_rd_q, q_rd_q, c_rd_q, d_rd_q;

	// Write ports: zero during clearing, updated entry on write back.
	logic            g_we, q_we, c_we, d_we;
	logic [G_AW-1:0] g_wa;
	logic [Q_AW-1:0] q_wa;
	logic [C_AW-1:0] c_wa;
	logic [D_AW-1:0] d_wa;
	tally_t          g_wd, q_wd, c_wd, d_wd;

	assign g_we = (cmd.clear_wr && (32'(clr_q) < G_DEPTH)) || (cmd.apply_wr && g_en_q);
	assign q_we = (cmd.clear_wr && (32'(clr_q) < Q_DEPTH)) || (cmd.apply_wr && q_en_q);
	assign c_we = cmd.clear_wr || (cmd.apply_wr && c_en_q);
	assign d_we = (cmd.clear_wr && (32'(clr_q) < D_DEPTH)) || (cmd.apply_wr && d_en_q);
	assign g_wa = cmd.clear_wr ? clr_q[G_AW-1:0] : g_addr_q;
	assign q_wa = cmd.clear_wr ? clr_q[Q_AW-1:0] : q_addr_q;
	assign c_wa = cmd.clear_wr ? clr_q : c_addr_q;
	assign d_wa = cmd.clear_wr ? clr_q[D_AW-1:0] : d_addr_q;
	assign g_wd = cmd.clear_wr ? '0 : bump(g_rd_q, err_q);
	assign q_wd = cmd.clear_wr ? '0 : bump(q_rd_q, err_q);
	assign c_wd = cmd.clear_wr ? '0 : bump(c_rd_q, err_q);
	assign d_wd = cmd.clear_wr ? '0 : bump(d_rd_q, err_q);

	always_ff @(posedge clk) begin
		if (g_we) begin
			g_mem[g_wa] <= g_wd;
		end
		if (cmd.mem_rd) begin
			g_rd_q <= g_mem[g_addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[q_wa] <= q_wd;
		end
		if (cmd.mem_rd) begin
			q_rd_q <= q_mem[q_addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (c_we) begin
			c_mem[c_wa] <= c_wd;
		end
		if (cmd.mem_rd) begin
			c_rd_q <= c_mem[c_addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (d_we) begin
			d_mem[d_wa] <= d_wd;
		end
		if (cmd.mem_rd) begin
			d_rd_q <= d_mem[d_addr_q];
		end
	end

	// Readout selection and output register.
	tally_t sel_entry;
	logic [OUT_DATA_W-1:0] out_q;

	always_comb begin
		unique case (sel_q)
			TBL_GROUP: sel_entry = g_rd_q;
			TBL_QUAL:  sel_entry = q_rd_q;
			TBL_CYCLE: sel_entry = c_rd_q;
			TBL_DINUC: sel_entry = d_rd_q;
			default:   sel_entry = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= rd_ok_q ? {clip(sel_entry.obs), clip(sel_entry.errs)} : '0;
		end
	end

	assign out_data = out_q;

endmodule

// File: rtl/covariate_error_histogram.sv
`timescale 1ns / 1ps

// Covariate error histogram: counts sequenced bases into four saturating tables
// (per read group; group and quality; group, quality, mate and cycle; group,
// quality and dinucleotide) and reads single entries back. A count item goes
// through accept, table read and write back, since every table is updated by a
// read-modify-write of its memory. A readout item goes through accept and
// table read as well, then loads its result once the output register is free;
// a count item gives no result. After reset the block runs a clearing pass
// over all tables, one entry per cycle in parallel, whose length is set by
// the cycle table and during which no item is taken.
module covariate_error_histogram (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [3:0] read_group, [9:4] qual, [17:10] cycle, [18] mate, [21:19] base,
	// [22] skipped, [23] error, [25:24] table_sel, [29:26] dinuc_code, rest zero
	input  logic [ceh_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// [0] op
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [31:0] error_count, [63:32] observation_count
	output logic [ceh_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
	import ceh_pkg::*;

	ceh_cmd_t    cmd;
	ceh_status_t status;

	// Sequencer.
	ceh_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cmd           (cmd),
		.status        (status)
	);

	// Tables, item registers and output register.
	ceh_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.in_op    (s_axis_tuser),
		.in_data  (s_axis_tdata),
		.out_data (m_axis_tdata)
	);

endmodule

// File: bench/ceh_tally_tracker.sv
`timescale 1ns / 1ps

// Watches both streams of the histogram block, keeps its own copy of the four
// counter tables, and compares every readout result with the counts expected
// at the time the readout item was accepted.
module ceh_tally_tracker
	import ceh_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	output int                    mismatches,
	output int                    awaiting
);

	localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;
	localparam longint unsigned OUT_MAX   = 64'hFFFF_FFFF;

	// Input item as laid out on s_axis_tdata, highest field first.
	typedef struct packed {
		logic [1:0]        pad;
		logic [DN_W-1:0]   dinuc_code;
		logic [SEL_W-1:0]  table_sel;
		logic              err;
		logic              skipped;
		logic [BASE_W-1:0] base;
		logic              mate;
		logic [CYC_W-1:0]  cyc;
		logic [QUAL_W-1:0] qual;
		logic [RG_W-1:0]   read_group;
	} base_item_t;

	typedef struct {
		longint unsigned errs;
		longint unsigned obs;
	} entry_tally_t;

	typedef struct {
		logic [OUT_W-1:0] errs;
		logic [OUT_W-1:0] obs;
	} readout_t;

	// Sparse copy of all tables, keyed by table and entry index.
	entry_tally_t      tally_store [longint unsigned];
	readout_t          expected_readouts [$];
	logic [BASE_W-1:0] last_base;

	function automatic longint unsigned tally_key(table_sel_t tbl, int unsigned idx);
		return {30'd0, tbl, idx};
	endfunction

	function automatic entry_tally_t fetch_tally(longint unsigned key);
		entry_tally_t t;
		t = '{0, 0};
		if (tally_store.exists(key)) begin
			t = tally_store[key];
		end
		return t;
	endfunction

	function automatic logic [OUT_W-1:0] clip_count(longint unsigned v);
		return (v > OUT_MAX) ? '1 : v[OUT_W-1:0];
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Saturating increment of one entry.
	task automatic bump_entry(table_sel_t tbl, int unsigned idx, logic err);
		longint unsigned key;
		entry_tally_t    t;
		key = tally_key(tbl, idx);
		t = fetch_tally(key);
		if (err && t.errs < COUNT_MAX) begin
			t.errs++;
		end
		if (t.obs < COUNT_MAX) begin
			t.obs++;
		end
		tally_store[key] = t;
	endtask

	// Apply one accepted item: a count updates the tables, a readout queues
	// the counts it must return. All field ranges fit the tables, so no
	// index can fall outside them.
	task automatic tally_item(logic [IN_DATA_W-1:0] data, logic user);
		base_item_t      it;
		logic [BASE_W-1:0] prev;
		int unsigned     qi;
		int unsigned     ci;
		longint unsigned key;
		entry_tally_t    t;
		readout_t        r;
		it = base_item_t'(data);
		qi = 32'(it.read_group) * QUAL_LEVELS + 32'(it.qual);
		ci = (qi * 2 + 32'(it.mate)) * MAX_CYCLES + 32'(it.cyc);
		if (user == OP_COUNT) begin
			prev = last_base;
			last_base = it.base;
			// Skipped bases and N (codes four to seven) are not counted.
			if (!it.skipped && it.base < BASE_N) begin
				bump_entry(TBL_GROUP, 32'(it.read_group), it.err);
				bump_entry(TBL_QUAL, qi, it.err);
				bump_entry(TBL_CYCLE, ci, it.err);
				if (prev < BASE_N && it.cyc != 0) begin
					bump_entry(TBL_DINUC,
						qi * DINUC_CODES + 32'(prev) * 4 + 32'(it.base), it.err);
				end
			end
		end else begin
			case (table_sel_t'(it.table_sel))
				TBL_GROUP: key = tally_key(TBL_GROUP, 32'(it.read_group));
				TBL_QUAL:  key = tally_key(TBL_QUAL, qi);
				TBL_CYCLE: key = tally_key(TBL_CYCLE, ci);
				default:   key = tally_key(TBL_DINUC,
					qi * DINUC_CODES + 32'(it.dinuc_code));
			endcase
			t = fetch_tally(key);
			r.errs = clip_count(t.errs);
			r.obs = clip_count(t.obs);
			expected_readouts = {expected_readouts, r};
		end
	endtask

	task automatic check_readout(logic [OUT_DATA_W-1:0] data);
		readout_t want;
		if (expected_readouts.size() == 0) begin
			report_mismatch($sformatf("result %h with no readout outstanding", data));
		end else begin
			want = expected_readouts.pop_front();
			if (data[OUT_W-1:0] !== want.errs) begin
				report_mismatch($sformatf("error_count %0d, expected %0d",
					data[OUT_W-1:0], want.errs));
			end
			if (data[2*OUT_W-1:OUT_W] !== want.obs) begin
				report_mismatch($sformatf("observation_count %0d, expected %0d",
					data[2*OUT_W-1:OUT_W], want.obs));
			end
		end
	endtask

	// Results are taken before items: a result never stems from an item
	// accepted at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_base = BASE_N;
			tally_store.delete();
			expected_readouts.delete();
			mismatches = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				check_readout(m_axis_tdata);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				tally_item(s_axis_tdata, s_axis_tuser);
			end
		end
		awaiting = expected_readouts.size();
	end

endmodule

// File: bench/tb_covariate_error_histogram.sv
`timescale 1ns / 1ps

module tb_covariate_error_histogram;
	import ceh_pkg::*;

	// The clearing pass after reset alone runs over every entry of the cycle table.
	localparam int IDLE_LIMIT  = 2000000;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEM_TOTAL  = 1375;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	int                mismatches;
	int                awaiting;
	int                idle_cycles = 0;
	int                items_sent = 0;
	int                hold_request = 0;
	int                hold_served = 0;
	bit                steady = 1'b0;
	logic [BASE_W-1:0] prev_code = BASE_N;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	covariate_error_histogram dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	ceh_tally_tracker tally_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.awaiting      (awaiting)
	);

	// Watchdog on cycles in which neither stream moves an item.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("covariate_error_histogram verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result side: random stalls, none while steady, and one long hold-off
	// whenever the stimulus asks for it.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_request) begin
				hold_served = hold_request;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				m_axis_tready <= steady || ($urandom_range(99) >= 25);
			end
		end
	end

	function automatic logic [IN_DATA_W-1:0] pack_item(
		logic [RG_W-1:0] rg, logic [QUAL_W-1:0] q, logic [CYC_W-1:0] cyc,
		logic mate, logic [BASE_W-1:0] b, logic skip, logic err,
		logic [SEL_W-1:0] sel, logic [DN_W-1:0] dn);
		return {2'b00, dn, sel, err, skip, b, mate, cyc, q, rg};
	endfunction

	// Offers one item, now and then after a random gap outside steady periods,
	// and returns at the falling edge after it was taken.
	task automatic send_item(op_t op, logic [IN_DATA_W-1:0] data);
		if (!steady && $urandom_range(99) < 25) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// Readout fields ride along as noise on a count item.
	task automatic count_base(logic [RG_W-1:0] rg, logic [QUAL_W-1:0] q,
		logic [CYC_W-1:0] cyc, logic mate, logic [BASE_W-1:0] b, logic skip,
		logic err);
		send_item(OP_COUNT, pack_item(rg, q, cyc, mate, b, skip, err,
			SEL_W'($urandom_range(3)), DN_W'($urandom_range(15))));
		prev_code = b;
	endtask

	// Base fields ride along as noise on a readout item.
	task automatic read_entry(table_sel_t sel, logic [RG_W-1:0] rg,
		logic [QUAL_W-1:0] q, logic [CYC_W-1:0] cyc, logic mate,
		logic [DN_W-1:0] dn);
		send_item(OP_READ, pack_item(rg, q, cyc, mate, BASE_W'($urandom_range(7)),
			1'($urandom_range(1)), 1'($urandom_range(1)), sel, dn));
	endtask

	function automatic logic [QUAL_W-1:0] pick_qual();
		case ($urandom_range(3))
			0:       return '0;
			1:       return '1;
			2:       return QUAL_W'(30);
			default: return QUAL_W'($urandom_range(63));
		endcase
	endfunction

	// One read: consecutive bases in one group and mate, mostly well formed,
	// with readouts of the entries just touched.
	task automatic stream_read();
		logic [RG_W-1:0]   rg;
		logic [QUAL_W-1:0] q;
		logic [QUAL_W-1:0] bq;
		logic [CYC_W-1:0]  cyc;
		logic [BASE_W-1:0] b;
		logic [BASE_W-1:0] p;
		logic [DN_W-1:0]   dn;
		logic              mate;
		int                len;
		int                pick;
		rg = ($urandom_range(9) < 7) ? RG_W'($urandom_range(3))
			: RG_W'($urandom_range(15));
		q = pick_qual();
		mate = 1'($urandom_range(1));
		cyc = ($urandom_range(9) < 8) ? '0 : CYC_W'($urandom_range(255));
		len = $urandom_range(3, 16);
		repeat (len) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				b = BASE_W'($urandom_range(3));
			end else if (pick < 92) begin
				b = BASE_N;
			end else begin
				b = BASE_W'($urandom_range(5, 7));
			end
			bq = ($urandom_range(9) < 8) ? q : QUAL_W'($urandom_range(63));
			p = prev_code;
			count_base(rg, bq, cyc, mate, b, $urandom_range(9) == 0,
				$urandom_range(9) < 3);
			if ($urandom_range(99) < 35) begin
				dn = (p < BASE_N && b < BASE_N && $urandom_range(9) < 7) ?
					{p[1:0], b[1:0]} : DN_W'($urandom_range(15));
				read_entry(table_sel_t'($urandom_range(3)), rg, bq, cyc, mate, dn);
			end
			cyc++;
		end
	endtask

	// Stray item with every field random.
	task automatic noise_item();
		logic [IN_DATA_W-1:0] data;
		op_t                  op;
		data = $urandom() & 32'h3FFF_FFFF;
		op = op_t'($urandom_range(1));
		send_item(op, data);
		if (op == OP_COUNT) begin
			prev_code = data[21:19];
		end
	endtask

	initial begin
		bit burst_done;
		bit pause_done;
		burst_done = 1'b0;
		pause_done = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extremes, cycle zero, N codes blocking the dinucleotide,
		// skipped bases, and readouts right behind the counts they depend on.
		read_entry(TBL_GROUP, 0, 0, 0, 0, 0);
		count_base(15, 63, 255, 1, 3, 0, 1);
		count_base(15, 63, 0, 0, 0, 0, 0);
		count_base(15, 63, 1, 0, 2, 0, 1);
		count_base(15, 63, 2, 0, 1, 1, 1);
		count_base(15, 63, 3, 0, 4, 0, 1);
		count_base(15, 63, 4, 0, 1, 0, 0);
		count_base(15, 63, 5, 0, 7, 0, 1);
		count_base(15, 63, 6, 0, 2, 0, 1);
		count_base(0, 0, 7, 1, 5, 0, 0);
		count_base(0, 0, 8, 1, 6, 0, 1);
		count_base(0, 0, 9, 1, 3, 0, 1);
		count_base(0, 0, 10, 1, 3, 0, 1);
		read_entry(TBL_DINUC, 0, 0, 0, 0, 15);
		read_entry(TBL_GROUP, 0, 0, 0, 0, 0);
		read_entry(TBL_QUAL, 0, 0, 0, 0, 0);
		read_entry(TBL_CYCLE, 0, 0, 10, 1, 0);
		read_entry(TBL_DINUC, 0, 0, 0, 0, 14);
		read_entry(TBL_GROUP, 15, 0, 0, 0, 0);
		read_entry(TBL_QUAL, 15, 63, 0, 0, 0);
		read_entry(TBL_CYCLE, 15, 63, 255, 1, 0);
		read_entry(TBL_CYCLE, 15, 63, 1, 0, 0);
		read_entry(TBL_DINUC, 15, 63, 0, 0, 2);
		read_entry(TBL_DINUC, 15, 63, 0, 0, 9);
		read_entry(TBL_DINUC, 15, 63, 0, 0, 3);

		// Random reads with some stray items in between.
		while (items_sent < ITEM_TOTAL) begin
			steady = (items_sent >= 600 && items_sent < 800);
			if (!burst_done && items_sent >= 350) begin
				// Stall the result side while readouts keep coming, so the
				// block backs up into its input.
				burst_done = 1'b1;
				steady = 1'b1;
				hold_request++;
				repeat (40) begin
					read_entry(table_sel_t'($urandom_range(3)), RG_W'($urandom_range(3)),
						pick_qual(), CYC_W'($urandom_range(15)), 1'($urandom_range(1)),
						DN_W'($urandom_range(15)));
				end
				steady = 1'b0;
			end else if (!pause_done && items_sent >= 1000) begin
				// Let the block drain completely before going on.
				pause_done = 1'b1;
				s_axis_tvalid <= 1'b0;
				while (awaiting != 0) @(negedge clk);
			end else if ($urandom_range(9) == 0) begin
				noise_item();
			end else begin
				stream_read();
			end
		end
		steady = 1'b0;
		s_axis_tvalid <= 1'b0;

		while (awaiting != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0 && awaiting == 0) begin
			$display("covariate_error_histogram verification clean");
		end else begin
			$display("covariate_error_histogram verification failed");
		end
		$finish;
	end

endmodule
